[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/emu_pkg.sv]
package emu_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned CntBits  = $clog2(WordBits);

  typedef logic [WordBits-1:0] word_t;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StBadMod    = 2'd1;
  localparam logic [1:0] StBadSecret = 2'd2;

  localparam logic CmdKey     = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  // Operand selection for one modular product.
  typedef enum logic [1:0] {
    MulRB  = 2'd0,  // r = r * b
    MulBB  = 2'd1,  // b = b * b
    MulYR  = 2'd2   // r = y2 * r
  } mul_sel_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic     load;       // capture operands and range status, clear reduction state
    logic     red_step;   // one reduction step on base/y2
    logic     mul_start;  // begin a modular product
    mul_sel_e mul_sel;
    logic     mul_step;   // one double-and-add step
    logic     mul_done;   // write the product back
    logic     exp_shift;  // shift exponent right
  } emu_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad_mod;
    logic bad_secret;
    logic exp_zero;
    logic exp_lsb;
    logic red_last;
    logic mul_last;
    logic is_decrypt;
  } emu_stat_t;

endpackage

[design/emu_if.sv]
interface emu_in_if import emu_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  command;
  word_t modulus;
  word_t base_value;
  word_t secret_exponent;
  word_t multiplier;
  modport source (output valid, command, modulus, base_value, secret_exponent,
                  multiplier, input ready);
  modport sink (input valid, command, modulus, base_value, secret_exponent,
                multiplier, output ready);
endinterface

interface emu_out_if import emu_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      value;
  logic [1:0] status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

[design/emu_datapath.sv]
module emu_datapath import emu_pkg::*; (
  input  logic       clk_i,
  input  logic       cmd_in_i,
  input  word_t      mod_in_i,
  input  word_t      base_in_i,
  input  word_t      exp_in_i,
  input  word_t      mul_in_i,
  input  emu_cmd_t   cmd_i,
  output emu_stat_t  stat_o,
  output word_t      value_o,
  output logic [1:0] status_o
);

  word_t p_q, b_q, r_q, y_q, e_q, acc_q, x_q, ymul_q, red_q;
  logic  dec_q;
  logic  phase_q;
  logic [CntBits-1:0] cnt_q;
  logic [1:0] st_q;

  // Modular add of values below p.
  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    word_t gap;
    gap = m - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  word_t sel_x, sel_y, acc_dbl, acc_nxt;
  logic  [WordBits:0] red_sh;
  word_t red_nxt;
  logic  bad_mod, bad_sec;

  // Pick product operands.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MulRB:   begin sel_x = r_q; sel_y = b_q; end
      MulBB:   begin sel_x = b_q; sel_y = b_q; end
      MulYR:   begin sel_x = r_q; sel_y = y_q; end
      default: begin sel_x = r_q; sel_y = b_q; end
    endcase
  end

  // Double-and-add step, MSB first over ymul_q.
  always_comb begin
    acc_dbl = add_mod(acc_q, acc_q, p_q);
    acc_nxt = ymul_q[WordBits-1] ? add_mod(acc_dbl, x_q, p_q) : acc_dbl;
  end

  // Restoring reduction step: red = (2*red + bit) mod p.
  always_comb begin
    red_sh  = {red_q, x_q[WordBits-1]};
    red_nxt = (red_sh >= {1'b0, p_q}) ? WordBits'(red_sh - {1'b0, p_q})
                                      : WordBits'(red_sh);
  end

  // Range checks on the incoming item.
  always_comb begin
    bad_mod = mod_in_i < WordBits'(3);
    bad_sec = (exp_in_i == '0) || (exp_in_i > mod_in_i - WordBits'(2));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q    <= mod_in_i;
      dec_q  <= cmd_in_i;
      e_q    <= (cmd_in_i == CmdDecrypt) ? mod_in_i - WordBits'(1) - exp_in_i
                                         : exp_in_i;
      r_q    <= WordBits'(1);
      x_q    <= base_in_i;
      ymul_q <= mul_in_i;
      red_q  <= '0;
      cnt_q  <= '0;
      st_q   <= bad_mod ? StBadMod : (bad_sec ? StBadSecret : StOk);
    end else if (cmd_i.red_step) begin
      // reduce base in x_q, then y2 held in ymul_q
      cnt_q <= cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(WordBits-1)) begin
        if (phase_q) y_q <= red_nxt;
        else b_q <= red_nxt;
        x_q   <= ymul_q;
        red_q <= '0;
      end else begin
        red_q <= red_nxt;
        x_q   <= {x_q[WordBits-2:0], 1'b0};
      end
    end else if (cmd_i.mul_start) begin
      acc_q  <= '0;
      x_q    <= sel_x;
      ymul_q <= sel_y;
      cnt_q  <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q  <= acc_nxt;
      ymul_q <= {ymul_q[WordBits-2:0], 1'b0};
      cnt_q  <= cnt_q + CntBits'(1);
    end else if (cmd_i.mul_done) begin
      unique case (cmd_i.mul_sel)
        MulBB:   b_q <= acc_q;
        default: r_q <= acc_q;
      endcase
    end
    if (cmd_i.exp_shift) e_q <= e_q >> 1;
  end

  // Track which reduction pass runs: base first, then y2.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) phase_q <= 1'b0;
    else if (cmd_i.red_step && cnt_q == CntBits'(WordBits-1)) phase_q <= 1'b1;
  end

  // Status back to the controller; r starts at 1, which is reduced for p >= 3.
  assign stat_o.bad_mod    = st_q == StBadMod;
  assign stat_o.bad_secret = st_q == StBadSecret;
  assign stat_o.exp_zero   = e_q == '0;
  assign stat_o.exp_lsb    = e_q[0];
  assign stat_o.red_last   = (cnt_q == CntBits'(WordBits-1)) && phase_q;
  assign stat_o.mul_last   = cnt_q == CntBits'(WordBits-1);
  assign stat_o.is_decrypt = dec_q;

  assign value_o  = (st_q == StOk) ? r_q : '0;
  assign status_o = st_q;

endmodule

[design/emu_ctrl.sv]
module emu_ctrl import emu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  emu_stat_t stat_i,
  output emu_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    SIdle  = 8'b0000_0001,
    SCheck = 8'b0000_0010,
    SRed   = 8'b0000_0100,
    SLoop  = 8'b0000_1000,
    SMul   = 8'b0001_0000,
    SWrite = 8'b0010_0000,
    SSq    = 8'b0100_0000,
    SOut   = 8'b1000_0000
  } state_e;

  state_e   state_q, state_d;
  mul_sel_e sel_q, sel_d;
  logic     fin_q, fin_d;  // final y2 product pending/done

  assign in_ready_o  = state_q == SIdle;
  assign out_valid_o = state_q == SOut;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.mul_sel = sel_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          fin_d      = 1'b0;
          state_d    = SCheck;
        end
      end
      SCheck: begin
        if (stat_i.bad_mod || stat_i.bad_secret) state_d = SOut;
        else state_d = SRed;
      end
      SRed: begin
        cmd_o.red_step = 1'b1;
        if (stat_i.red_last) state_d = SLoop;
      end
      SLoop: begin
        // pick next product, or finish
        if (stat_i.exp_zero) begin
          if (stat_i.is_decrypt && !fin_q) begin
            sel_d = MulYR; fin_d = 1'b1;
            cmd_o.mul_sel = MulYR; cmd_o.mul_start = 1'b1;
            state_d = SMul;
          end else state_d = SOut;
        end else if (stat_i.exp_lsb) begin
          sel_d = MulRB; cmd_o.mul_sel = MulRB; cmd_o.mul_start = 1'b1;
          state_d = SMul;
        end else state_d = SSq;
      end
      SSq: begin
        sel_d = MulBB; cmd_o.mul_sel = MulBB; cmd_o.mul_start = 1'b1;
        state_d = SMul;
      end
      SMul: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) state_d = SWrite;
      end
      SWrite: begin
        cmd_o.mul_done = 1'b1;
        if (sel_q == MulRB) state_d = SSq;
        else if (sel_q == MulBB) begin
          cmd_o.exp_shift = 1'b1;
          state_d = SLoop;
        end else state_d = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      sel_q   <= MulRB;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      fin_q   <= fin_d;
    end
  end

endmodule

[design/elgamal_modexp_unit_core.sv]
// ElGamal modular exponentiation unit, 64-bit prime modulus.
// Input channel in_if carries command, modulus, base_value, secret_exponent
// and multiplier; output channel out_if carries value and status.
// Command 0 returns base^secret mod p; command 1 returns
// multiplier * base^(p-1-secret) mod p. Status 1 flags p below 3,
// status 2 a secret outside 1..p-2; value is then 0.
// One item is in flight at a time: in_if.ready is high only while idle.
// A rejected item goes from the check state straight to output. Otherwise a
// check state and 64 restoring reduction steps each for base and y2 come
// first, then per exponent bit one loop state and one squaring (64
// double-and-add steps on the shared modular multiplier plus start and
// write-back); a set bit adds a multiply started in the loop state. One
// closing loop state follows; decrypt starts its final multiply there.
// The result holds on out_if until taken; a stalled receiver simply keeps
// the unit busy. Reset returns the controller to idle with no item pending.
module elgamal_modexp_unit_core import emu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  emu_in_if.sink    in_if,
  emu_out_if.source out_if
);

  emu_cmd_t  cmd;
  emu_stat_t stat;

  emu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  emu_datapath u_dp (
    .clk_i     (clk_i),
    .cmd_in_i  (in_if.command),
    .mod_in_i  (in_if.modulus),
    .base_in_i (in_if.base_value),
    .exp_in_i  (in_if.secret_exponent),
    .mul_in_i  (in_if.multiplier),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .value_o   (out_if.value),
    .status_o  (out_if.status)
  );

endmodule

[design/emu_checker.sv]
`include "assert_macros.svh"

module emu_checker import emu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] out_status_i,
  input word_t out_value_i
);

  // Never busy on both sides at once.
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_i, !in_ready_i)
  // An accepted item makes the unit busy.
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // Error results carry zero value.
  `ASSERT_IMPL(a_zero, clk_i, rst_ni, out_valid_i && out_status_i != StOk, out_value_i == '0)
  // Status code stays in range.
  `ASSERT_IMPL(a_stat, clk_i, rst_ni, out_valid_i, out_status_i != 2'd3)
  // Stalled result holds.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_value_i))

endmodule

bind elgamal_modexp_unit_core emu_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_status_i (out_if.status),
  .out_value_i  (out_if.value)
);
